[rtl/sma_crossover_regime_signal_top_macros.svh]
// Assertion macros for the moving average crossover block.
// Included by the top level; depends on nothing else.
`ifndef SMA_CROSSOVER_REGIME_SIGNAL_TOP_MACROS_SVH
`define SMA_CROSSOVER_REGIME_SIGNAL_TOP_MACROS_SVH

// Same-cycle implication, reset masked.
`define SCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset masked.
`define SCS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/scs_pkg.sv]
// Shared types, constants and helpers for the moving average crossover block.
// Used by scs_div and sma_crossover_regime_signal_top.
`timescale 1ns / 1ps
`default_nettype none
package scs_pkg;

  localparam int HISTORY_DEPTH_DEF = 512;
  localparam int PRICE_WIDTH_DEF   = 32;

  localparam int FIELD_W     = 32;
  localparam int LEN_W       = 9;
  localparam int EXT_W       = 18;
  localparam int TICK_W      = 16;
  localparam int CNT_W       = 10;
  localparam int CNT_MAX     = 1023;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 18;
  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 168;
  localparam int OUT_PAD_W   = 4;

  // Divider sizing for the default price width.
  localparam int DIV_DVW_DEF = PRICE_WIDTH_DEF + 16;
  localparam int DIV_DSW_DEF = PRICE_WIDTH_DEF;

  localparam int FAST_LO = 2;
  localparam int FAST_HI = 500;
  localparam int SLOW_LO = 3;
  localparam int SLOW_HI = 500;
  localparam int IDX_LO  = 3;
  localparam int IDX_HI  = 500;
  localparam int ROC_LO  = 2;
  localparam int ROC_HI  = 200;

  localparam int ROC_SCALE  = 25600;
  localparam int SCORE_BIAS = 25856;
  localparam int SCORE_ONE  = 256;
  localparam logic [63:0] SCORE_SAT_LIMIT = 64'd2147509504;
  localparam logic [FIELD_W-1:0] SCORE_MIN = 32'h8000_0000;

  localparam logic             RST_ENABLED   = 1'b1;
  localparam logic [LEN_W-1:0] RST_FAST_LEN  = 9'd50;
  localparam logic [LEN_W-1:0] RST_SLOW_LEN  = 9'd200;
  localparam logic [LEN_W-1:0] RST_IDX_LEN   = 9'd200;
  localparam logic [7:0]       RST_ROC_LEN   = 8'd20;
  localparam logic [EXT_W-1:0] RST_MAX_EXT   = 18'd68813;
  localparam logic [TICK_W-1:0] RST_TICK     = 16'd1;
  localparam logic             RST_IDX_EN    = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLED   = 3'd0,
    CFG_FAST_LEN  = 3'd1,
    CFG_SLOW_LEN  = 3'd2,
    CFG_IDX_LEN   = 3'd3,
    CFG_ROC_LEN   = 3'd4,
    CFG_MAX_EXT   = 3'd5,
    CFG_TICK      = 3'd6,
    CFG_IDX_EN    = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_DRAIN,
    ST_MUL,
    ST_MULW,
    ST_COMP,
    ST_DIV,
    ST_DIVW,
    ST_RESULT
  } state_t;

  // Products formed on the shared multiplier, in issue order.
  typedef enum logic [2:0] {
    MS_REGIME = 3'd0,
    MS_FPREV  = 3'd1,
    MS_SPREV  = 3'd2,
    MS_FCUR   = 3'd3,
    MS_SCUR   = 3'd4,
    MS_CLOSE  = 3'd5,
    MS_LIMIT  = 3'd6,
    MS_ROC    = 3'd7
  } mul_sel_t;

  typedef enum logic [1:0] {
    DS_FAST  = 2'd0,
    DS_SLOW  = 2'd1,
    DS_SCORE = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic [FIELD_W-1:0] sell_mark;
    logic [FIELD_W-1:0] buy_mark;
    logic [FIELD_W-1:0] score;
    logic [FIELD_W-1:0] slow_average;
    logic [FIELD_W-1:0] fast_average;
    logic               holding;
    logic               sell;
    logic               buy;
    logic               halted;
  } out_word_t;

  function automatic int clamp_len(int v, int lo, int hi, int depth);
    int r;
    r = v;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    if (r > depth - 1) r = depth - 1;
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/sma_crossover_regime_signal_top.sv]
// Moving average crossover with index regime filter: top level.
// Depends on scs_pkg, scs_div and sma_crossover_regime_signal_top_macros.svh.
//
// Usage: one price bar enters on the in_ channel, one result word leaves on
// the out_ channel. Registers are to be written on the cfg_ channel while
// idle; the block itself does not enforce this. Each bar is processed alone;
// in_tready is high only while the sequencer waits for a bar. A bar that
// arrives while disabled or that fails the gate goes straight from the write
// state to the result state. A bar with full averages, the index filter on
// and enough index bars scans both history rings once, one entry per cycle,
// for K+1 entries where K is the largest of fast_len, slow_len, index_len-1
// and roc_len; then a drain state, eight products on the shared multiplier,
// a compare state, three passes of the divider and the output state.
// The ring scan and the bit-serial divider take most of the time per bar.
// Reset clears the position, counters and configuration to their defaults;
// history is not cleared and needs no warm-up pass. A stalled receiver keeps
// the result in the output register; a later bar waits in ST_RESULT.
`timescale 1ns / 1ps
`default_nettype none
`include "sma_crossover_regime_signal_top_macros.svh"
module sma_crossover_regime_signal_top #(
  parameter int HISTORY_DEPTH = scs_pkg::HISTORY_DEPTH_DEF,
  parameter int PRICE_WIDTH   = scs_pkg::PRICE_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // close_price, high_price, low_price, index_close, restart, zero pad
  input  wire logic [scs_pkg::IN_TDATA_W-1:0]   in_tdata,
  // index_present
  input  wire logic                             in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // halted, buy, sell, holding, fast_average, slow_average, score,
  // buy_mark, sell_mark, zero pad
  output logic [scs_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // computed
  output logic                                  out_tuser,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [scs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [scs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import scs_pkg::*;

  localparam int PW   = PRICE_WIDTH;
  localparam int AW   = $clog2(HISTORY_DEPTH);
  localparam int SUMW = PW + LEN_W;
  localparam int PRW  = SUMW + EXT_W;
  localparam int DVW  = PW + 16;
  localparam int DSW  = PW;

  // Configuration registers.
  logic              en_r, idx_en_r;
  logic [LEN_W-1:0]  fast_len_r, slow_len_r, idx_len_r;
  logic [7:0]        roc_len_r;
  logic [EXT_W-1:0]  max_ext_r;
  logic [TICK_W-1:0] tick_r;

  state_t state_r, state_nxt;

  logic [PW-1:0] close_r, high_r, low_r, idxc_r;
  logic          present_r, restart_r;

  logic [AW-1:0]    wslot_r, cur_slot, rd_addr_r;
  logic [CNT_W-1:0] bars_r, run_r, ibar_r;
  logic [CNT_W-1:0] bars_base, run_base, run_new;
  logic             pos_r, gate_r, gate_w;

  logic [LEN_W-1:0] f_len, s_len, i_len, r_len, need, kmax;
  logic [LEN_W-1:0] k_r, kd_r;
  logic             rdv_r;

  logic [PW-1:0] close_mem [HISTORY_DEPTH];
  logic [PW-1:0] idx_mem   [HISTORY_DEPTH];
  logic [PW-1:0] cmem_q, imem_q;

  logic [SUMW-1:0] fsum_r, fprev_r, ssum_r, sprev_r, isum_r;
  logic [PW-1:0]   prev_r;

  mul_sel_t        msel_r;
  logic [SUMW-1:0] mul_a;
  logic [EXT_W-1:0] mul_b;
  logic [PRW-1:0]  mul_p_r;
  logic [PRW-1:0]  prod_r [8];

  logic regime_r, golden_r, death_r, ext_ok_r;

  div_sel_t        dsel_r;
  logic [DVW-1:0]  div_dividend, div_q;
  logic [DSW-1:0]  div_divisor;
  logic            div_start, div_done;
  logic [FIELD_W-1:0] fast_avg_r, slow_avg_r;
  logic [DVW-1:0]  roc_q_r;

  logic       mem_we, load_out;
  out_word_t  res_w, out_res_r;
  logic       computed_w, out_computed_r, out_valid_r, pos_new;
  logic [FIELD_W-1:0] score_w;
  logic [PW:0]   sell_sum;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r       <= RST_ENABLED;
      fast_len_r <= RST_FAST_LEN;
      slow_len_r <= RST_SLOW_LEN;
      idx_len_r  <= RST_IDX_LEN;
      roc_len_r  <= RST_ROC_LEN;
      max_ext_r  <= RST_MAX_EXT;
      tick_r     <= RST_TICK;
      idx_en_r   <= RST_IDX_EN;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ENABLED:  en_r       <= cfg_data[0];
        CFG_FAST_LEN: fast_len_r <= cfg_data[LEN_W-1:0];
        CFG_SLOW_LEN: slow_len_r <= cfg_data[LEN_W-1:0];
        CFG_IDX_LEN:  idx_len_r  <= cfg_data[LEN_W-1:0];
        CFG_ROC_LEN:  roc_len_r  <= cfg_data[7:0];
        CFG_MAX_EXT:  max_ext_r  <= cfg_data[EXT_W-1:0];
        CFG_TICK:     tick_r     <= cfg_data[TICK_W-1:0];
        CFG_IDX_EN:   idx_en_r   <= cfg_data[0];
      endcase
    end
  end

  // The scan must reach one entry past the longer moving average window.
  always_comb begin
    f_len = LEN_W'(clamp_len(int'(fast_len_r), FAST_LO, FAST_HI, HISTORY_DEPTH));
    s_len = LEN_W'(clamp_len(int'(slow_len_r), SLOW_LO, SLOW_HI, HISTORY_DEPTH));
    i_len = LEN_W'(clamp_len(int'(idx_len_r), IDX_LO, IDX_HI, HISTORY_DEPTH));
    r_len = LEN_W'(clamp_len(int'(roc_len_r), ROC_LO, ROC_HI, HISTORY_DEPTH));
    need  = (s_len > f_len) ? s_len : f_len;
    kmax  = need;
    if (i_len - 1'b1 > kmax) kmax = i_len - 1'b1;
    if (r_len > kmax) kmax = r_len;
  end

  // ---------------- series bookkeeping ----------------
  always_comb begin
    cur_slot  = restart_r ? '0 : wslot_r;
    bars_base = restart_r ? '0 : bars_r;
    run_base  = restart_r ? '0 : run_r;
    if (!present_r) begin
      run_new = '0;
    end else if (run_base < CNT_W'(CNT_MAX)) begin
      run_new = run_base + 1'b1;
    end else begin
      run_new = run_base;
    end
    gate_w = (bars_base >= CNT_W'(need)) && idx_en_r && (run_new >= CNT_W'(i_len));
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_WRITE;
      ST_WRITE:  state_nxt = (en_r && gate_w) ? ST_SCAN : ST_RESULT;
      ST_SCAN:   if (k_r == kmax) state_nxt = ST_DRAIN;
      ST_DRAIN:  state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_MULW;
      ST_MULW:   state_nxt = (msel_r == MS_ROC) ? ST_COMP : ST_MUL;
      ST_COMP:   state_nxt = ST_DIV;
      ST_DIV:    state_nxt = ST_DIVW;
      ST_DIVW:   if (div_done) state_nxt = (dsel_r == DS_SCORE) ? ST_RESULT : ST_DIV;
      ST_RESULT: if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    mem_we    = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_tready = 1'b1;
      ST_WRITE:  mem_we    = en_r;
      ST_DIV:    div_start = 1'b1;
      ST_RESULT: load_out  = !out_valid_r || out_tready;
      default:   ;
    endcase
  end

  // ---------------- history rings ----------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      close_mem[cur_slot] <= close_r;
    end
    cmem_q <= close_mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      idx_mem[cur_slot] <= idxc_r;
    end
    imem_q <= idx_mem[rd_addr_r];
  end

  // ---------------- control state ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wslot_r <= '0;
      bars_r  <= '0;
      run_r   <= '0;
      pos_r   <= 1'b0;
      rdv_r   <= 1'b0;
      k_r     <= '0;
      msel_r  <= MS_REGIME;
      dsel_r  <= DS_FAST;
      gate_r  <= 1'b0;
    end else begin
      rdv_r <= (state_r == ST_SCAN);
      if (state_r == ST_WRITE && en_r) begin
        wslot_r <= (cur_slot == AW'(HISTORY_DEPTH - 1)) ? '0 : cur_slot + 1'b1;
        run_r   <= run_new;
        bars_r  <= (bars_base < CNT_W'(CNT_MAX)) ? bars_base + 1'b1 : bars_base;
        if (restart_r) pos_r <= 1'b0;
        gate_r  <= gate_w;
        k_r     <= '0;
      end
      if (state_r == ST_SCAN) begin
        k_r <= k_r + 1'b1;
      end
      if (state_r == ST_DRAIN) begin
        msel_r <= MS_REGIME;
      end
      if (state_r == ST_MULW) begin
        msel_r <= mul_sel_t'(msel_r + 1'b1);
      end
      if (state_r == ST_COMP) begin
        dsel_r <= DS_FAST;
      end
      if (state_r == ST_DIVW && div_done && dsel_r != DS_SCORE) begin
        dsel_r <= div_sel_t'(dsel_r + 1'b1);
      end
      if (load_out && en_r && gate_r) begin
        pos_r <= pos_new;
      end
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid) begin
      close_r   <= PW'(in_tdata[31:0]);
      high_r    <= PW'(in_tdata[63:32]);
      low_r     <= PW'(in_tdata[95:64]);
      idxc_r    <= PW'(in_tdata[127:96]);
      restart_r <= in_tdata[128];
      present_r <= in_tuser;
    end
    if (state_r == ST_WRITE) begin
      ibar_r    <= bars_base;
      rd_addr_r <= cur_slot;
      fsum_r    <= '0;
      fprev_r   <= '0;
      ssum_r    <= '0;
      sprev_r   <= '0;
      isum_r    <= '0;
      prev_r    <= '0;
    end
    if (state_r == ST_SCAN) begin
      rd_addr_r <= (rd_addr_r == '0) ? AW'(HISTORY_DEPTH - 1) : rd_addr_r - 1'b1;
      kd_r      <= k_r;
    end
    // Entry kd_r bars back from the current one has just come out of the rings.
    if (rdv_r) begin
      if (kd_r < f_len) fsum_r <= fsum_r + SUMW'(cmem_q);
      if (kd_r != '0 && kd_r <= f_len) fprev_r <= fprev_r + SUMW'(cmem_q);
      if (kd_r < s_len) ssum_r <= ssum_r + SUMW'(cmem_q);
      if (kd_r != '0 && kd_r <= s_len) sprev_r <= sprev_r + SUMW'(cmem_q);
      if (kd_r < i_len) isum_r <= isum_r + SUMW'(imem_q);
      if (kd_r == r_len) prev_r <= cmem_q;
    end
    if (state_r == ST_MUL) begin
      mul_p_r <= PRW'(mul_a) * PRW'(mul_b);
    end
    if (state_r == ST_MULW) begin
      prod_r[msel_r] <= mul_p_r;
    end
    if (state_r == ST_COMP) begin
      regime_r <= prod_r[MS_REGIME] > PRW'(isum_r);
      golden_r <= (prod_r[MS_FPREV] <= prod_r[MS_SPREV]) &&
                  (prod_r[MS_FCUR] > prod_r[MS_SCUR]);
      death_r  <= (prod_r[MS_FPREV] >= prod_r[MS_SPREV]) &&
                  (prod_r[MS_FCUR] < prod_r[MS_SCUR]);
      ext_ok_r <= {prod_r[MS_CLOSE], 16'b0} < (PRW+16)'(prod_r[MS_LIMIT]);
    end
    if (state_r == ST_DIVW && div_done) begin
      case (dsel_r)
        DS_FAST:  fast_avg_r <= FIELD_W'(div_q);
        DS_SLOW:  slow_avg_r <= FIELD_W'(div_q);
        default:  roc_q_r    <= div_q;
      endcase
    end
  end

  always_comb begin
    case (msel_r)
      MS_REGIME: begin mul_a = SUMW'(idxc_r);  mul_b = EXT_W'(i_len); end
      MS_FPREV:  begin mul_a = fprev_r;        mul_b = EXT_W'(s_len); end
      MS_SPREV:  begin mul_a = sprev_r;        mul_b = EXT_W'(f_len); end
      MS_FCUR:   begin mul_a = fsum_r;         mul_b = EXT_W'(s_len); end
      MS_SCUR:   begin mul_a = ssum_r;         mul_b = EXT_W'(f_len); end
      MS_CLOSE:  begin mul_a = SUMW'(close_r); mul_b = EXT_W'(s_len); end
      MS_LIMIT:  begin mul_a = ssum_r;         mul_b = max_ext_r;     end
      default:   begin mul_a = SUMW'(close_r); mul_b = EXT_W'(ROC_SCALE); end
    endcase
  end

  // Rounded half up: the half divisor is folded into the dividend.
  always_comb begin
    case (dsel_r)
      DS_FAST: begin
        div_dividend = DVW'(fsum_r) + DVW'(f_len >> 1);
        div_divisor  = DSW'(f_len);
      end
      DS_SLOW: begin
        div_dividend = DVW'(ssum_r) + DVW'(s_len >> 1);
        div_divisor  = DSW'(s_len);
      end
      default: begin
        div_dividend = DVW'(prod_r[MS_ROC]) + DVW'(prev_r >> 1);
        div_divisor  = prev_r;
      end
    endcase
  end

  scs_div #(
    .DVW (DVW),
    .DSW (DSW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // ---------------- result ----------------
  always_comb begin
    if (ibar_r < CNT_W'(r_len)) begin
      score_w = '0;
    end else if (prev_r == '0) begin
      score_w = FIELD_W'(SCORE_ONE);
    end else if (64'(roc_q_r) > SCORE_SAT_LIMIT) begin
      score_w = SCORE_MIN;
    end else begin
      score_w = FIELD_W'(SCORE_BIAS) - roc_q_r[FIELD_W-1:0];
    end
    sell_sum = (PW+1)'(high_r) + (PW+1)'(tick_r);

    res_w      = '0;
    computed_w = 1'b0;
    pos_new    = pos_r;
    if (en_r) begin
      res_w.halted = 1'b1;
      if (gate_r) begin
        computed_w         = 1'b1;
        res_w.halted       = !regime_r;
        res_w.fast_average = fast_avg_r;
        res_w.slow_average = slow_avg_r;
        res_w.score        = score_w;
        if (pos_r) begin
          if (death_r) begin
            pos_new         = 1'b0;
            res_w.sell      = 1'b1;
            res_w.sell_mark = sell_sum[PW] ? {FIELD_W{1'b1}} & FIELD_W'({PW{1'b1}})
                                           : FIELD_W'(sell_sum[PW-1:0]);
          end
        end else if (regime_r && golden_r && ext_ok_r) begin
          pos_new        = 1'b1;
          res_w.buy      = 1'b1;
          res_w.buy_mark = (low_r > PW'(tick_r)) ? FIELD_W'(low_r - PW'(tick_r)) : '0;
        end
      end
      res_w.holding = pos_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res_r      <= res_w;
      out_computed_r <= computed_w;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_res_r};
  assign out_tuser  = out_computed_r;

  // ---------------- checks ----------------
  `SCS_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready, "bar accepted while busy")
  `SCS_ASSERT_NOW(a_buy_holds, clk, rst_n, out_tvalid && out_res_r.buy, out_res_r.holding && !out_res_r.sell, "buy without position")
  `SCS_ASSERT_NOW(a_sell_flat, clk, rst_n, out_tvalid && out_res_r.sell, !out_res_r.holding, "sell left position open")

endmodule
`default_nettype wire

[rtl/scs_div.sv]
// Restoring divider, one quotient bit per cycle.
// Uses scs_pkg for default widths; instantiated by the top level.
`timescale 1ns / 1ps
`default_nettype none
module scs_div #(
  parameter int DVW = scs_pkg::DIV_DVW_DEF,
  parameter int DSW = scs_pkg::DIV_DSW_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [DVW-1:0] dividend,
  input  wire logic [DSW-1:0] divisor,
  output logic                done,
  output logic [DVW-1:0]      quotient
);
  import scs_pkg::*;

  localparam int CW = $clog2(DVW + 1);

  logic [DVW-1:0] q_r, q_nxt;
  logic [DSW-1:0] rem_r, rem_nxt;
  logic [DSW-1:0] dsr_r;
  logic [CW-1:0]  cnt_r;
  logic           busy_r, done_r;
  logic [DSW:0]   rem_sh;
  logic [DSW+1:0] diff;
  logic           ge;

  always_comb begin
    rem_sh  = {rem_r, q_r[DVW-1]};
    diff    = (DSW+2)'(rem_sh) - (DSW+2)'(dsr_r);
    ge      = !diff[DSW+1];
    rem_nxt = ge ? diff[DSW-1:0] : rem_sh[DSW-1:0];
    q_nxt   = {q_r[DVW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DVW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule
`default_nettype wire
